// ===== rtl/swm_pkg.sv =====
// Shared types, constants and helpers for the sliding-window median filter.
`timescale 1ns / 1ps

package swm_pkg;

    localparam int WINDOW_MAX   = 64;
    localparam int SAMPLE_WIDTH = 32;

    // Fixed field widths of the channels and the configuration register
    localparam int SAMPLE_BITS = 32;
    localparam int MED_W       = 33;
    localparam int CFG_BITS    = 7;

    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);

    localparam logic [CFG_BITS-1:0] WINDOW_SIZE_RESET = CFG_BITS'(3);

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic [CNT_W-1:0]               count_t;
    typedef logic [IDX_W-1:0]               index_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_REMOVE,
        CELL_INSERT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        sample_t  key;
    } cell_ctrl_t;

    typedef struct packed {
        logic    valid;
        sample_t value;
    } cell_tap_t;

    // Clamp a raw window size into 1..WINDOW_MAX
    function automatic count_t eff_window(input logic [CFG_BITS-1:0] ws);
        count_t w;
        if (ws == '0)
        begin
            w = count_t'(1);
        end
        else if (32'(ws) > 32'(WINDOW_MAX))
        begin
            w = count_t'(WINDOW_MAX);
        end
        else
        begin
            w = count_t'(ws);
        end
        return w;
    endfunction

endpackage

// ===== rtl/swm_if.sv =====
// Valid/ready channel interfaces for samples in and medians out.
`timescale 1ns / 1ps

interface swm_in_if;
    import swm_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          restart;

    modport source (output valid, output sample, output restart, input ready);
    modport sink   (input valid, input sample, input restart, output ready);
endinterface

interface swm_out_if;
    import swm_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [MED_W-1:0] median_doubled;

    modport source (output valid, output median_doubled, input ready);
    modport sink   (input valid, input median_doubled, output ready);
endinterface

// ===== rtl/swm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module swm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/swm_cell.sv =====
// One cell of the sorted window chain: holds one sample, trades with neighbors.
`timescale 1ns / 1ps

module swm_cell (
    input  logic                clk,
    input  swm_pkg::cell_ctrl_t ctrl,
    input  logic                self_valid,
    input  swm_pkg::cell_tap_t  left,
    input  swm_pkg::cell_tap_t  right,
    output swm_pkg::sample_t    value
);
    import swm_pkg::*;

    sample_t value_reg;
    sample_t value_next;

    always_comb
    begin
        value_next = value_reg;
        unique case (ctrl.op)
            CELL_REMOVE:
            begin
                // Close the gap: every cell at or past the removed entry pulls from the right
                if (!right.valid || (right.value > ctrl.key))
                begin
                    value_next = right.value;
                end
            end
            CELL_INSERT:
            begin
                if (self_valid && (value_reg <= ctrl.key))
                begin
                    value_next = value_reg;
                end
                else if (left.valid && (left.value > ctrl.key))
                begin
                    value_next = left.value;
                end
                else
                begin
                    value_next = ctrl.key;
                end
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// ===== rtl/sliding_window_median.sv =====
// Top level of the sliding-window median filter.
`timescale 1ns / 1ps

// Running median over the last window_size samples, returned doubled (sum of the two
// middle samples, or twice the middle one for an odd window). A sample that gives no
// result passes the accept with arrival-ring read, the removal pass over the sorted
// cell chain and the insertion pass; one that gives a result also has the median pick
// into the output register, which stalls until that register is free. A new sample
// is accepted only once the previous one has finished. A finished median waits in the
// output register while the next sample is accepted. No result comes out until the
// window is full; restart or a window_size write empties the window.
module sliding_window_median (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [swm_pkg::CFG_BITS-1:0]   cfg_wdata,
    swm_in_if.sink                         samples,
    swm_out_if.source                      medians
);
    import swm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_REMOVE,
        S_INSERT,
        S_MEDIAN
    } state_t;

    state_t                  state_reg;
    count_t                  win_reg;
    count_t                  fill_reg;
    index_t                  oldest_reg;
    logic                    full_reg;
    sample_t                 key_reg;
    logic                    out_valid_reg;
    logic signed [MED_W-1:0] out_data_reg;

    logic       accept;
    logic       clear_acc;
    count_t     fill_acc;
    index_t     oldest_acc;
    sample_t    sample_in;
    sample_t    ring_rdata;
    logic       ring_we;
    index_t     ring_waddr;
    cell_ctrl_t ctrl;
    count_t     cell_count;
    logic       cell_valid [WINDOW_MAX];
    sample_t    cell_value [WINDOW_MAX];
    index_t     lo_idx;
    index_t     hi_idx;
    logic signed [MED_W-1:0] median_sum;
    logic       out_free;
    logic       med_load;

    assign accept    = samples.valid && samples.ready;
    assign sample_in = sample_t'(samples.sample[SAMPLE_WIDTH-1:0]);

    // Start a fresh sequence on restart or an inconsistent fill level
    assign clear_acc  = samples.restart || (fill_reg > win_reg);
    assign fill_acc   = clear_acc ? '0 : fill_reg;
    assign oldest_acc = (clear_acc || (count_t'(oldest_reg) >= win_reg)) ? '0 : oldest_reg;

    assign ring_we    = (state_reg == S_REMOVE);
    assign ring_waddr = full_reg ? oldest_reg : fill_reg[IDX_W-1:0];

    swm_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (key_reg),
        .re    (accept),
        .raddr (oldest_acc),
        .rdata (ring_rdata)
    );

    always_comb
    begin
        ctrl.op    = CELL_HOLD;
        ctrl.key   = key_reg;
        cell_count = full_reg ? (win_reg - count_t'(1)) : fill_reg;
        unique case (state_reg)
            S_REMOVE:
            begin
                if (full_reg)
                begin
                    ctrl.op = CELL_REMOVE;
                end
                ctrl.key   = ring_rdata;
                cell_count = win_reg;
            end
            S_INSERT:
            begin
                ctrl.op = CELL_INSERT;
            end
            default:
            begin
                ctrl.op = CELL_HOLD;
            end
        endcase
    end

    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_cell
        cell_tap_t left_tap;
        cell_tap_t right_tap;

        assign cell_valid[i] = (count_t'(i) < cell_count);

        if (i == 0)
        begin : g_first
            assign left_tap = '0;
        end
        else
        begin : g_left
            assign left_tap = '{valid: cell_valid[i-1], value: cell_value[i-1]};
        end

        if (i == WINDOW_MAX - 1)
        begin : g_last
            assign right_tap = '0;
        end
        else
        begin : g_right
            assign right_tap = '{valid: cell_valid[i+1], value: cell_value[i+1]};
        end

        swm_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .self_valid (cell_valid[i]),
            .left       (left_tap),
            .right      (right_tap),
            .value      (cell_value[i])
        );
    end

    // Middle entries; they coincide for an odd window
    assign lo_idx     = IDX_W'((win_reg - count_t'(1)) >> 1);
    assign hi_idx     = IDX_W'(win_reg >> 1);
    assign median_sum = MED_W'(cell_value[lo_idx]) + MED_W'(cell_value[hi_idx]);
    assign out_free   = !out_valid_reg || medians.ready;
    assign med_load   = !cfg_we && (state_reg == S_MEDIAN) && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            win_reg       <= eff_window(WINDOW_SIZE_RESET);
            fill_reg      <= '0;
            oldest_reg    <= '0;
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (medians.valid && medians.ready && !med_load)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                win_reg    <= eff_window(cfg_wdata);
                fill_reg   <= '0;
                oldest_reg <= '0;
            end
            else
            begin
                unique case (state_reg)
                    S_IDLE:
                    begin
                        if (accept)
                        begin
                            key_reg    <= sample_in;
                            fill_reg   <= fill_acc;
                            oldest_reg <= oldest_acc;
                            full_reg   <= (fill_acc == win_reg);
                            state_reg  <= S_REMOVE;
                        end
                    end
                    S_REMOVE:
                    begin
                        if (full_reg)
                        begin
                            // Advance the oldest slot around the ring
                            if ((count_t'(oldest_reg) + count_t'(1)) == win_reg)
                            begin
                                oldest_reg <= '0;
                            end
                            else
                            begin
                                oldest_reg <= oldest_reg + index_t'(1);
                            end
                        end
                        state_reg <= S_INSERT;
                    end
                    S_INSERT:
                    begin
                        if (full_reg)
                        begin
                            state_reg <= S_MEDIAN;
                        end
                        else
                        begin
                            fill_reg <= fill_reg + count_t'(1);
                            if ((fill_reg + count_t'(1)) == win_reg)
                            begin
                                state_reg <= S_MEDIAN;
                            end
                            else
                            begin
                                state_reg <= S_IDLE;
                            end
                        end
                    end
                    S_MEDIAN:
                    begin
                        // Hold until the previous beat has left the output register
                        if (med_load)
                        begin
                            out_data_reg  <= median_sum;
                            out_valid_reg <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                    end
                    default:
                    begin
                        state_reg <= S_IDLE;
                    end
                endcase
            end
        end
    end

    assign samples.ready          = (state_reg == S_IDLE);
    assign medians.valid          = out_valid_reg;
    assign medians.median_doubled = out_data_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= win_reg)
        else $error("fill level exceeds window size");

    a_oldest_full: assert property (@(posedge clk) disable iff (!rst_n)
        (oldest_reg != '0) |-> (fill_reg == win_reg))
        else $error("ring pointer moved before the window was full");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_MEDIAN))
        else $error("result beat raised outside the median pick");

    a_sorted_middle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MEDIAN) |-> (cell_value[lo_idx] <= cell_value[hi_idx]))
        else $error("middle entries of the chain out of order");

endmodule

// ===== verif/sliding_window_median_tb.sv =====
// Self-checking testbench for the sliding-window median filter.
`timescale 1ns / 1ps

module sliding_window_median_tb;
    import swm_pkg::*;

    typedef logic signed [MED_W-1:0] med_t;
    typedef logic [CFG_BITS-1:0]     wsize_t;
    typedef enum logic { ROW_SAMPLE, ROW_WSIZE } row_kind_t;

    typedef struct {
        row_kind_t kind;
        sample_t   value;
        logic      restart;
        logic      typed;
        med_t      median;
    } stim_row_t;

    localparam int     SETTLE_CYCLES = 12;
    localparam int     HOLD_CYCLES   = 200;
    localparam int     NUM_PHASES    = 10;
    localparam sample_t S_MAX = 32'sh7FFF_FFFF;
    localparam sample_t S_MIN = 32'sh8000_0000;
    localparam med_t    M_TOP = 33'h0_FFFF_FFFE;
    localparam med_t    M_BOT = 33'h1_0000_0000;

    logic   clk;
    logic   rst_n;
    logic   cfg_we;
    wsize_t cfg_wdata;

    swm_in_if  samples_ch ();
    swm_out_if medians_ch ();

    sliding_window_median dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .samples   (samples_ch.sink),
        .medians   (medians_ch.source)
    );

    // Predictor state: samples held in arrival order and the clamped window size
    sample_t   held_samples[$];
    int        win_eff;
    med_t      pending_medians[$];
    med_t      want_median;
    int        errors = 0;
    int        snd_idle_pct;
    int        rcv_idle_pct;
    bit        hold_req;
    stim_row_t stim_rows[$];

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic predict_median(input sample_t s, input logic rs, output med_t med);
        sample_t srt[$];
        sample_t v;
        int      j;
        med = '0;
        if (rs)
        begin
            held_samples.delete();
        end
        if (held_samples.size() >= win_eff)
        begin
            held_samples.delete(0);
        end
        held_samples.insert(held_samples.size(), s);
        if (held_samples.size() < win_eff)
        begin
            return 1'b0;
        end
        foreach (held_samples[i])
        begin
            v = held_samples[i];
            j = 0;
            while (j < srt.size() && srt[j] <= v)
            begin
                j++;
            end
            srt.insert(j, v);
        end
        if (win_eff % 2)
        begin
            med = med_t'(srt[win_eff / 2]) + med_t'(srt[win_eff / 2]);
        end
        else
        begin
            med = med_t'(srt[win_eff / 2 - 1]) + med_t'(srt[win_eff / 2]);
        end
        return 1'b1;
    endfunction

    function automatic void row_sample(input sample_t s, input logic rs);
        stim_row_t row;
        row = '{ROW_SAMPLE, s, rs, 1'b0, med_t'(0)};
        stim_rows.insert(stim_rows.size(), row);
    endfunction

    function automatic void row_checked(input sample_t s, input logic rs, input med_t m);
        stim_row_t row;
        row = '{ROW_SAMPLE, s, rs, 1'b1, m};
        stim_rows.insert(stim_rows.size(), row);
    endfunction

    function automatic void row_wsize(input int ws);
        stim_row_t row;
        row = '{ROW_WSIZE, sample_t'(ws), 1'b0, 1'b0, med_t'(0)};
        stim_rows.insert(stim_rows.size(), row);
    endfunction

    task automatic send_sample(input sample_t s, input logic rs, input logic typed,
                               input med_t typed_med);
        med_t m;
        int   gap;
        if ($urandom_range(0, 99) < snd_idle_pct)
        begin
            samples_ch.valid <= 1'b0;
            gap = $urandom_range(1, 13);
            repeat (gap) @(posedge clk);
        end
        if (predict_median(s, rs, m))
        begin
            pending_medians.insert(pending_medians.size(), typed ? typed_med : m);
        end
        samples_ch.valid   <= 1'b1;
        samples_ch.sample  <= s;
        samples_ch.restart <= rs;
        @(posedge clk);
        while (!samples_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    // Drop valid, drain all medians, then let samples that give none finish
    task automatic settle();
        samples_ch.valid <= 1'b0;
        while (pending_medians.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_window(input wsize_t ws);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= ws;
        @(posedge clk);
        cfg_we  <= 1'b0;
        win_eff = (ws == 0) ? 1 : ((int'(ws) > WINDOW_MAX) ? WINDOW_MAX : int'(ws));
        held_samples.delete();
    endtask

    // Sink side: random stall bursts, plus one long hold-off on request
    initial
    begin
        int burst;
        bit hold_done;
        hold_done = 1'b0;
        medians_ch.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                medians_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
                medians_ch.ready <= 1'b1;
            end
            else if ($urandom_range(0, 99) < rcv_idle_pct)
            begin
                medians_ch.ready <= 1'b0;
                burst = $urandom_range(1, 13);
                repeat (burst) @(posedge clk);
                medians_ch.ready <= 1'b1;
            end
            else
            begin
                medians_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && medians_ch.valid && medians_ch.ready)
        begin
            if (pending_medians.size() == 0)
            begin
                errors++;
                $display("%0t: median with none pending, expected none, actual %0d",
                         $time, medians_ch.median_doubled);
            end
            else
            begin
                want_median = pending_medians[0];
                pending_medians.delete(0);
                if (medians_ch.median_doubled !== want_median)
                begin
                    errors++;
                    $display("%0t: median mismatch, expected %0d, actual %0d",
                             $time, want_median, medians_ch.median_doubled);
                end
            end
        end
    end

    initial
    begin
        wsize_t  ph_ws[NUM_PHASES];
        int      ph_items[NUM_PHASES];
        sample_t s;
        logic    rs;
        int      rs_pct;

        hold_req     = 1'b0;
        snd_idle_pct = 20;
        rcv_idle_pct = 20;
        win_eff      = int'(WINDOW_SIZE_RESET);
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;
        samples_ch.valid   = 1'b0;
        samples_ch.sample  = '0;
        samples_ch.restart = 1'b0;

        // Window of 3 after reset: extremes, restart, equal samples
        row_sample(0, 1'b0);
        row_sample(0, 1'b0);
        row_checked(0, 1'b0, 33'sd0);
        row_checked(S_MAX, 1'b0, 33'sd0);
        row_checked(S_MAX, 1'b0, M_TOP);
        row_checked(S_MAX, 1'b0, M_TOP);
        row_sample(S_MIN, 1'b1);
        row_sample(S_MIN, 1'b0);
        row_checked(S_MIN, 1'b0, M_BOT);
        row_checked(S_MAX, 1'b0, M_BOT);
        row_checked(-1, 1'b0, -33'sd2);
        row_checked(1, 1'b0, 33'sd2);
        row_sample(7, 1'b1);
        row_sample(7, 1'b0);
        row_checked(3, 1'b0, 33'sd14);
        row_checked(7, 1'b0, 33'sd14);
        row_checked(3, 1'b0, 33'sd6);
        row_sample(32'sh5555_5555, 1'b0);
        row_sample(32'shAAAA_AAAA, 1'b0);
        // Even window: sum of the two middle samples
        row_wsize(2);
        row_sample(S_MAX, 1'b0);
        row_checked(S_MAX, 1'b0, M_TOP);
        row_checked(S_MIN, 1'b0, -33'sd1);
        row_checked(S_MIN, 1'b0, M_BOT);
        // Zero acts as a window of one
        row_wsize(0);
        row_checked(S_MAX, 1'b0, M_TOP);
        row_checked(S_MIN, 1'b0, M_BOT);

        ph_ws[0] = wsize_t'(1);    ph_items[0] = 40;
        ph_ws[1] = wsize_t'(2);    ph_items[1] = 50;
        ph_ws[2] = wsize_t'(64);   ph_items[2] = 110;
        ph_ws[3] = wsize_t'(127);  ph_items[3] = 80;
        ph_ws[4] = wsize_t'(0);    ph_items[4] = 30;
        ph_ws[5] = wsize_t'(65);   ph_items[5] = 80;
        ph_ws[6] = wsize_t'(4);    ph_items[6] = 50;
        ph_ws[7] = wsize_t'($urandom_range(3, 63)); ph_items[7] = 50;
        ph_ws[8] = wsize_t'($urandom_range(1, 127)); ph_items[8] = 60;
        ph_ws[9] = wsize_t'(5);    ph_items[9] = 50;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[r])
        begin
            if (stim_rows[r].kind == ROW_WSIZE)
            begin
                write_window(wsize_t'(stim_rows[r].value));
            end
            else
            begin
                send_sample(stim_rows[r].value, stim_rows[r].restart,
                            stim_rows[r].typed, stim_rows[r].median);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_window(ph_ws[p]);
            if (p == NUM_PHASES - 1)
            begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            else
            begin
                snd_idle_pct = $urandom_range(0, 2) * 15;
                rcv_idle_pct = $urandom_range(0, 2) * 15;
            end
            // Keep offering samples while the sink holds off, so the block backs up
            if (p == 1)
            begin
                hold_req = 1'b1;
            end
            rs_pct = (win_eff <= 8) ? 5 : 1;
            for (int k = 0; k < ph_items[p]; k++)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: s = $urandom;
                    5, 6, 7:       s = sample_t'($urandom_range(0, 6)) - 3;
                    8:             s = $urandom_range(0, 1) ? S_MAX : S_MIN;
                    default:       s = $signed($urandom) >>> $urandom_range(1, 30);
                endcase
                rs = ($urandom_range(0, 99) < rs_pct);
                send_sample(s, rs, 1'b0, med_t'(0));
            end
        end

        settle();
        if (errors == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
